// ===== hw/rtl/sfdf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfdf_pkg
// Shared types and constants for the sync-framed deframer with Fletcher-16.
// ----------------------------------------------------------------------------
package sfdf_pkg;

    // APB register map (word addressed, register i at byte 4*i)
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic REG_ADDRESS_MODE = 1'b0;
    localparam logic REG_QUICK_FILTER = 1'b1;

    // Sync pair
    localparam logic [7:0] SYNC_FIRST  = 8'h55;   // 'U'
    localparam logic [7:0] SYNC_SECOND = 8'h24;   // '$'

    // Fletcher sums after folding in the sync pair 'U','$'
    localparam logic [7:0] FL_MOD       = 8'd255;
    localparam logic [7:0] SYNC_SUM_LOW  = 8'd121;
    localparam logic [7:0] SYNC_SUM_HIGH = 8'd206;

    // Quick filter set
    localparam logic [7:0] TYPE_Q1  = 8'd1;
    localparam logic [7:0] TYPE_Q16 = 8'd16;
    localparam logic [7:0] TYPE_Q33 = 8'd33;
    localparam logic [7:0] TYPE_Q81 = 8'd81;
    localparam logic [7:0] FIRST_BYTE_Q33 = 8'd1;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_TYPE,
        PH_ACTION,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_ADDR,
        PH_PAYLOAD,
        PH_CK1,
        PH_CK2
    } t_phase;

    typedef struct packed {
        logic       address_mode;
        logic       quick_filter;
    } t_cfg;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_of_stream;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  frame_type;
        logic [7:0]  frame_action;
        logic [15:0] payload_length;
        logic [31:0] dest_field;
        logic [31:0] source_field;
        logic [7:0]  payload_byte;
        logic        byte_present;
        logic        frame_end;
        logic        frame_good;
    } t_out_beat;

endpackage
`default_nettype wire

// ===== hw/rtl/sfdf_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfdf_regs
// APB configuration registers: address mode and quick filter.
// ----------------------------------------------------------------------------
module sfdf_regs (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_psel,
    input  wire                                 i_penable,
    input  wire                                 i_pwrite,
    input  wire [sfdf_pkg::CFG_ADDR_W-1:0]      i_paddr,
    input  wire [sfdf_pkg::CFG_DATA_W-1:0]      i_pwdata,
    output logic [sfdf_pkg::CFG_DATA_W-1:0]     o_prdata,
    output logic                                o_pready,
    output sfdf_pkg::t_cfg                      o_cfg
);

    sfdf_pkg::t_cfg r_cfg;
    logic           wr_en;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (i_paddr[2])
                sfdf_pkg::REG_ADDRESS_MODE: r_cfg.address_mode <= i_pwdata[0];
                sfdf_pkg::REG_QUICK_FILTER: r_cfg.quick_filter <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        unique case (i_paddr[2])
            sfdf_pkg::REG_ADDRESS_MODE: o_prdata[0] = r_cfg.address_mode;
            sfdf_pkg::REG_QUICK_FILTER: o_prdata[0] = r_cfg.quick_filter;
            default: ;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== hw/rtl/sfdf_fletcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfdf_fletcher
// Fletcher-16 running sums, mod 255, one byte per cycle while i_add is set.
// ----------------------------------------------------------------------------
module sfdf_fletcher (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_load_sync,   // restart with the sync pair folded in
    input  wire        i_add,
    input  wire [7:0]  i_byte,
    output logic       o_next_zero    // both sums zero after this byte
);

    logic [7:0] r_low, r_high;
    logic [7:0] n_low, n_high;
    logic [8:0] s1_raw, s2_raw;

    always_comb begin
        s1_raw = {1'b0, r_low} + {1'b0, i_byte};
        if (s1_raw >= {1'b0, sfdf_pkg::FL_MOD}) begin
            s1_raw = s1_raw - {1'b0, sfdf_pkg::FL_MOD};
        end
        n_low  = s1_raw[7:0];
        s2_raw = {1'b0, r_high} + {1'b0, n_low};
        if (s2_raw >= {1'b0, sfdf_pkg::FL_MOD}) begin
            s2_raw = s2_raw - {1'b0, sfdf_pkg::FL_MOD};
        end
        n_high = s2_raw[7:0];
    end

    assign o_next_zero = (n_low == 8'd0) && (n_high == 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
        end else if (i_load_sync) begin
            r_low  <= sfdf_pkg::SYNC_SUM_LOW;
            r_high <= sfdf_pkg::SYNC_SUM_HIGH;
        end else if (i_add) begin
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/sfdf_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfdf_core
// Frame parser: sync hunt, header capture, payload pass-through, verdict.
// One byte handled per advance; result is combinational from state + byte.
// ----------------------------------------------------------------------------
module sfdf_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_advance,
    input  sfdf_pkg::t_in_beat   i_beat,
    input  sfdf_pkg::t_cfg       i_cfg,
    output logic                 o_res_valid,
    output sfdf_pkg::t_out_beat  o_res
);

    sfdf_pkg::t_phase r_phase, n_phase;
    logic        r_saw_u, n_saw_u;
    logic [15:0] r_fc, n_fc;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_action, n_action;
    logic [15:0] r_len, n_len;
    logic [31:0] r_dest, n_dest;
    logic [31:0] r_src, n_src;
    logic        r_drop, n_drop;

    logic        fl_load, fl_add, fl_zero;
    logic        hunt, done, silent, emit;
    logic [7:0]  b;
    logic        eos;
    logic [2:0]  k;
    logic [4:0]  shamt;
    logic [15:0] fc_inc;

    function automatic logic in_quick_set(input logic [7:0] t);
        return (t == sfdf_pkg::TYPE_Q1) || (t == sfdf_pkg::TYPE_Q16) ||
               (t == sfdf_pkg::TYPE_Q33) || (t == sfdf_pkg::TYPE_Q81);
    endfunction

    sfdf_fletcher u_fl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load_sync (fl_load),
        .i_add       (fl_add),
        .i_byte      (b),
        .o_next_zero (fl_zero)
    );

    assign b      = i_beat.stream_byte;
    assign eos    = i_beat.end_of_stream;
    assign k      = r_fc[2:0];
    assign shamt  = {k[1:0], 3'b000};
    assign fc_inc = r_fc + 16'd1;

    always_comb begin
        n_phase  = r_phase;
        n_saw_u  = r_saw_u;
        n_fc     = r_fc;
        n_type   = r_type;
        n_action = r_action;
        n_len    = r_len;
        n_dest   = r_dest;
        n_src    = r_src;
        n_drop   = r_drop;
        fl_load  = 1'b0;
        fl_add   = 1'b0;
        hunt     = 1'b0;
        done     = 1'b0;
        silent   = 1'b0;
        emit     = 1'b0;
        o_res_valid        = 1'b0;
        o_res.payload_byte = '0;
        o_res.byte_present = 1'b0;
        o_res.frame_end    = 1'b0;
        o_res.frame_good   = 1'b0;

        if (i_advance) begin
            fl_add = (r_phase != sfdf_pkg::PH_HUNT);
            unique case (r_phase)
                sfdf_pkg::PH_HUNT: begin
                    if (r_saw_u && b == sfdf_pkg::SYNC_SECOND) begin
                        n_phase  = sfdf_pkg::PH_TYPE;
                        n_saw_u  = 1'b0;
                        fl_load  = 1'b1;
                        n_type   = '0;
                        n_action = '0;
                        n_len    = '0;
                        n_dest   = '0;
                        n_src    = '0;
                        n_drop   = 1'b0;
                        n_fc     = '0;
                    end else begin
                        n_saw_u = (b == sfdf_pkg::SYNC_FIRST);
                    end
                    hunt = eos;
                    done = 1'b1;
                end
                sfdf_pkg::PH_TYPE: begin
                    n_type = b;
                    if (i_cfg.quick_filter && !in_quick_set(b)) begin
                        hunt = 1'b1;
                        done = 1'b1;
                    end else begin
                        n_phase = sfdf_pkg::PH_ACTION;
                    end
                end
                sfdf_pkg::PH_ACTION: begin
                    n_action = b;
                    n_phase  = sfdf_pkg::PH_LEN_LO;
                end
                sfdf_pkg::PH_LEN_LO: begin
                    n_len   = {8'd0, b};
                    n_phase = sfdf_pkg::PH_LEN_HI;
                end
                sfdf_pkg::PH_LEN_HI: begin
                    n_len = {b, r_len[7:0]};
                    n_fc  = '0;
                    if (i_cfg.address_mode) begin
                        n_phase = sfdf_pkg::PH_ADDR;
                    end else if (n_len != 16'd0) begin
                        n_phase = sfdf_pkg::PH_PAYLOAD;
                    end else if (i_cfg.quick_filter && r_type == sfdf_pkg::TYPE_Q33) begin
                        hunt   = 1'b1;
                        silent = 1'b1;
                    end else begin
                        n_phase = sfdf_pkg::PH_CK1;
                    end
                end
                sfdf_pkg::PH_ADDR: begin
                    if (!k[2]) begin
                        n_dest = r_dest | (32'(b) << shamt);
                    end else begin
                        n_src = r_src | (32'(b) << shamt);
                    end
                    n_fc = 16'(k) + 16'd1;
                    if (k == 3'd7) begin
                        n_fc = '0;
                        if (r_len != 16'd0) begin
                            n_phase = sfdf_pkg::PH_PAYLOAD;
                        end else if (i_cfg.quick_filter && r_type == sfdf_pkg::TYPE_Q33) begin
                            hunt   = 1'b1;
                            silent = 1'b1;
                        end else begin
                            n_phase = sfdf_pkg::PH_CK1;
                        end
                    end
                end
                sfdf_pkg::PH_PAYLOAD: begin
                    n_drop = r_drop | ((r_fc == 16'd0) && i_cfg.quick_filter &&
                             (r_type == sfdf_pkg::TYPE_Q33) &&
                             (b != sfdf_pkg::FIRST_BYTE_Q33));
                    n_fc = fc_inc;
                    if (n_drop) begin
                        silent = 1'b1;
                        if (fc_inc == r_len) begin
                            hunt = 1'b1;
                            done = 1'b1;
                        end
                    end else begin
                        emit = 1'b1;
                        if (fc_inc == r_len) begin
                            n_phase = sfdf_pkg::PH_CK1;
                        end
                    end
                end
                sfdf_pkg::PH_CK1: begin
                    n_phase = sfdf_pkg::PH_CK2;
                end
                default: begin
                    // second checksum byte: verdict
                    o_res_valid      = 1'b1;
                    o_res.frame_end  = 1'b1;
                    o_res.frame_good = fl_zero;
                    hunt = 1'b1;
                    done = 1'b1;
                end
            endcase

            if (!done && eos) begin
                hunt = 1'b1;
                if (!silent) begin
                    o_res_valid        = 1'b1;
                    o_res.frame_end    = 1'b1;
                    o_res.byte_present = emit;
                    o_res.payload_byte = emit ? b : 8'd0;
                end
            end else if (!done && emit) begin
                o_res_valid        = 1'b1;
                o_res.byte_present = 1'b1;
                o_res.payload_byte = b;
            end

            if (hunt) begin
                n_phase = sfdf_pkg::PH_HUNT;
                n_saw_u = 1'b0;
                n_drop  = 1'b0;
                n_fc    = '0;
            end
        end

        o_res.frame_type     = n_type;
        o_res.frame_action   = n_action;
        o_res.payload_length = n_len;
        o_res.dest_field     = n_dest;
        o_res.source_field   = n_src;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sfdf_pkg::PH_HUNT;
            r_saw_u  <= 1'b0;
            r_fc     <= '0;
            r_type   <= '0;
            r_action <= '0;
            r_len    <= '0;
            r_dest   <= '0;
            r_src    <= '0;
            r_drop   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_saw_u  <= n_saw_u;
            r_fc     <= n_fc;
            r_type   <= n_type;
            r_action <= n_action;
            r_len    <= n_len;
            r_dest   <= n_dest;
            r_src    <= n_src;
            r_drop   <= n_drop;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/sync_frame_deframer_fletcher16_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_frame_deframer_fletcher16_top
// Sync-framed packet deframer with Fletcher-16 frame check.
// ----------------------------------------------------------------------------
// Takes one stream byte per beat, hunts for the sync pair 'U','$', captures
// type, action, little-endian size and (in address mode) destination and
// source words, then hands each payload byte out as a result beat carrying
// the header fields. The second checksum byte yields an end-marker beat whose
// frame_good flag is set when both Fletcher-16 sums (mod 255, taken over the
// whole frame from the sync pair to the last checksum byte) are zero. A byte
// flagged end_of_stream inside a frame closes it with frame_good low. Quick
// filter drops types outside 1/16/33/81 and type 33 frames whose first
// payload byte is not 1 or that have no payload, with no beats out. Payload
// bytes leave before the verdict is known. Throughput is one byte per clock,
// sustained while i_out_ready is high; a beat passes the input register, the
// combinational parse step and then the result register. Configuration is by
// APB: address_mode at 0x0, quick_filter at 0x4 (bit 0); the user must write
// them only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module sync_frame_deframer_fletcher16_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // input stream
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  sfdf_pkg::t_in_beat                  i_in_data,
    // result stream
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output sfdf_pkg::t_out_beat                 o_out_data,
    // APB config
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [sfdf_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire [sfdf_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [sfdf_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    sfdf_pkg::t_cfg      cfg;
    sfdf_pkg::t_in_beat  r_in;
    logic                r_in_valid;
    sfdf_pkg::t_out_beat r_out;
    logic                r_out_valid;
    sfdf_pkg::t_out_beat res;
    logic                res_valid;
    logic                advance;
    logic                in_acc;

    sfdf_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    // Parse the held beat when the result register is free or draining.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
    end

    sfdf_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_beat      (r_in),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register; a beat with no result leaves it empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== hw/rtl/sfdf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfdf_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sfdf_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              o_out_valid,
    input  wire                              i_out_ready,
    input  sfdf_pkg::t_out_beat              o_out_data,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [sfdf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire [sfdf_pkg::CFG_DATA_W-1:0]   pwdata,
    input  wire [sfdf_pkg::CFG_DATA_W-1:0]   prdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    // an end marker always closes the frame
    a_marker_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.byte_present |-> o_out_data.frame_end)
        else $error("end marker without frame_end");

    // good verdict only on an end marker
    a_good_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_good |->
            !o_out_data.byte_present && o_out_data.frame_end)
        else $error("frame_good on a payload beat");

    // address_mode readback follows the last write
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[2] == sfdf_pkg::REG_ADDRESS_MODE) |=>
            (paddr[2] != sfdf_pkg::REG_ADDRESS_MODE) || (prdata[0] == $past(pwdata[0])))
        else $error("address_mode readback mismatch");

endmodule

bind sync_frame_deframer_fletcher16_top sfdf_checker u_sfdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);
`default_nettype wire
